// ----- rtl/core/pngu_pkg.sv -----
// ----------------------------------------------------------------------------
// pngu_pkg
// Shared types and constants of the scanline unfilter: channel structs,
// register indexes and the decoded filter operation.
// ----------------------------------------------------------------------------
package pngu_pkg;

	// configuration register indexes
	localparam logic [1:0] REG_WIDTH = 2'd0;
	localparam logic [1:0] REG_ROWS  = 2'd1;
	localparam logic [1:0] REG_BPP   = 2'd2;

	localparam int CFG_DATA_W = 16;
	// width for line length and counter compares, holds a line of 65536 bytes
	localparam int CALC_W = 17;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SUB,
		OP_UP,
		OP_AVG,
		OP_PAETH,
		OP_PASS
	} op_t;

	typedef struct packed {
		logic [7:0] filtered_byte;
		logic       image_start;
	} in_item_t;

	typedef struct packed {
		logic [7:0] pixel_byte;
		logic       end_of_row;
		logic       end_of_image;
		logic       bad_filter;
	} out_item_t;

	typedef struct packed {
		logic [11:0] width_pixels;
		logic [15:0] image_rows;
		logic [3:0]  bytes_per_pixel;
	} cfg_t;

	// one classified data byte on its way to the reconstruction side
	typedef struct packed {
		logic [7:0]  x;
		op_t         op;
		logic [15:0] addr;
		logic [2:0]  slot;
		logic        has_left;
		logic        has_up;
		logic        eor;
		logic        eoi;
	} work_t;

endpackage

// ----- rtl/core/pngu_fifo.sv -----
// ----------------------------------------------------------------------------
// pngu_fifo
// Small flip-flop queue with full and empty flags.
// ----------------------------------------------------------------------------
module pngu_fifo #(
	parameter type entry_t = logic,
	parameter int  DEPTH   = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t wr,
	output logic   full,
	input  logic   pop,
	output entry_t rd,
	output logic   empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PW-1:0]      wr_ptr_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd      = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr;
		end
	end

endmodule

// ----- rtl/core/pngu_front.sv -----
// ----------------------------------------------------------------------------
// pngu_front
// Stream front end: row and column counters, filter byte capture and
// classification of each data byte for the reconstruction side.
// ----------------------------------------------------------------------------
module pngu_front #(
	parameter int MAX_LINE_BYTES      = 16384,
	parameter int MAX_BYTES_PER_PIXEL = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  pngu_pkg::in_item_t item,
	output logic              full,
	input  pngu_pkg::cfg_t    cfg,
	input  logic              bpp_written,
	input  logic              q_full,
	output logic              q_push,
	output pngu_pkg::work_t   q_entry
);

	localparam int CW = $clog2(MAX_LINE_BYTES);
	localparam int BW = $clog2(CW);
	localparam int SW = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;
	localparam int XW = pngu_pkg::CALC_W;

	logic [CW-1:0]  col_q;
	logic [15:0]    row_q;
	logic [SW-1:0]  slot_q;
	logic           expect_q;
	pngu_pkg::op_t  row_op_q;

	// slot resync after a bytes_per_pixel write: col mod bpp, one bit per cycle
	logic           rs_busy_q;
	logic [BW-1:0]  rs_bit_q;
	logic [2:0]     rs_rem_q;
	logic [3:0]     rs_step;
	logic [2:0]     rs_next;

	logic           accept;
	logic           is_filter;
	logic [3:0]     bpp_eff;
	logic [11:0]    w_eff;
	logic [15:0]    rows_eff;
	logic [XW-1:0]  line_len;
	logic [XW-1:0]  prod;
	logic [XW-1:0]  col_inc;
	logic           eor;
	logic           eoi;
	pngu_pkg::op_t  op_new;

	always_comb begin
		bpp_eff = cfg.bytes_per_pixel;
		if (cfg.bytes_per_pixel == 4'd0) begin
			bpp_eff = 4'd1;
		end else if (cfg.bytes_per_pixel > 4'(MAX_BYTES_PER_PIXEL)) begin
			bpp_eff = 4'(MAX_BYTES_PER_PIXEL);
		end
		w_eff    = (cfg.width_pixels == '0) ? 12'd1 : cfg.width_pixels;
		rows_eff = (cfg.image_rows == '0) ? 16'd1 : cfg.image_rows;
		prod     = XW'(w_eff) * XW'(bpp_eff);
		line_len = (prod > XW'(MAX_LINE_BYTES)) ? XW'(MAX_LINE_BYTES) : prod;
		col_inc  = XW'(col_q) + XW'(1);
	end

	assign full      = q_full || rs_busy_q;
	assign accept    = push && !full;
	// image_start forces the filter byte of row 0
	assign is_filter = item.image_start || expect_q;
	assign eor       = (col_inc >= line_len);
	assign eoi       = (XW'(row_q) + XW'(1)) >= XW'(rows_eff);
	assign q_push    = accept && !is_filter;

	always_comb begin
		case (item.filtered_byte) inside
			8'd0:    op_new = pngu_pkg::OP_NONE;
			8'd1:    op_new = pngu_pkg::OP_SUB;
			8'd2:    op_new = pngu_pkg::OP_UP;
			8'd3:    op_new = pngu_pkg::OP_AVG;
			8'd4:    op_new = pngu_pkg::OP_PAETH;
			default: op_new = pngu_pkg::OP_PASS;
		endcase
	end

	always_comb begin
		q_entry          = '0;
		q_entry.x        = item.filtered_byte;
		q_entry.op       = row_op_q;
		q_entry.addr     = 16'(col_q);
		q_entry.slot     = 3'(slot_q);
		q_entry.has_left = (XW'(col_q) >= XW'(bpp_eff));
		q_entry.has_up   = (row_q != '0);
		q_entry.eor      = eor;
		q_entry.eoi      = eor && eoi;
	end

	always_comb begin
		rs_step = {rs_rem_q, col_q[rs_bit_q]};
		rs_next = (rs_step >= bpp_eff) ? 3'(rs_step - bpp_eff) : 3'(rs_step);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= '0;
			slot_q    <= '0;
			expect_q  <= 1'b1;
			row_op_q  <= pngu_pkg::OP_NONE;
			rs_busy_q <= 1'b0;
			rs_bit_q  <= '0;
			rs_rem_q  <= '0;
		end else begin
			if (bpp_written) begin
				rs_busy_q <= 1'b1;
				rs_bit_q  <= BW'(CW - 1);
				rs_rem_q  <= '0;
			end else if (rs_busy_q) begin
				rs_rem_q <= rs_next;
				if (rs_bit_q == '0) begin
					rs_busy_q <= 1'b0;
					slot_q    <= SW'(rs_next);
				end else begin
					rs_bit_q <= rs_bit_q - BW'(1);
				end
			end
			if (accept) begin
				if (is_filter) begin
					row_op_q <= op_new;
					col_q    <= '0;
					slot_q   <= '0;
					expect_q <= 1'b0;
					if (item.image_start) begin
						row_q <= '0;
					end
				end else if (eor) begin
					col_q    <= '0;
					slot_q   <= '0;
					expect_q <= 1'b1;
					row_q    <= eoi ? '0 : row_q + 16'd1;
				end else begin
					col_q  <= CW'(col_inc);
					slot_q <= ((4'(slot_q) + 4'd1) >= bpp_eff) ? '0 : slot_q + SW'(1);
				end
			end
		end
	end

endmodule

// ----- rtl/core/pngu_back.sv -----
// ----------------------------------------------------------------------------
// pngu_back
// Reconstruction side: previous-row line store, left and above-left pixel
// windows, and the None/Sub/Up/Average/Paeth rules.
// ----------------------------------------------------------------------------
module pngu_back #(
	parameter int MAX_LINE_BYTES      = 16384,
	parameter int MAX_BYTES_PER_PIXEL = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_empty,
	input  pngu_pkg::work_t     q_head,
	output logic                q_pop,
	input  logic                r_full,
	output logic                r_push,
	output pngu_pkg::out_item_t r_item
);

	localparam int AW = $clog2(MAX_LINE_BYTES);
	localparam int SW = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

	logic [7:0]      line_mem [MAX_LINE_BYTES];
	logic [7:0]      left_q   [MAX_BYTES_PER_PIXEL];
	logic [7:0]      upleft_q [MAX_BYTES_PER_PIXEL];

	logic            v_s2;
	pngu_pkg::work_t ent_s2;
	logic [7:0]      rd_s2;
	logic            fwd_s2;
	logic [7:0]      fwd_d_s2;

	logic            advance;
	logic            take;
	logic            wr_en;
	logic [AW-1:0]   wr_addr;
	logic [SW-1:0]   slot;
	logic [7:0]      a;
	logic [7:0]      b;
	logic [7:0]      c;
	logic [8:0]      ab_sum;
	logic [7:0]      recon;

	function automatic logic [7:0] paeth_pred(logic [7:0] pa_in, logic [7:0] pb_in,
		logic [7:0] pc_in);
		logic signed [10:0] da;
		logic signed [10:0] db;
		logic signed [10:0] dc;
		logic [9:0]         pa;
		logic [9:0]         pb;
		logic [9:0]         pc;
		logic [7:0]         pick;
		da = $signed({3'b000, pb_in}) - $signed({3'b000, pc_in});
		db = $signed({3'b000, pa_in}) - $signed({3'b000, pc_in});
		dc = da + db;
		pa = da[10] ? 10'(-da) : 10'(da);
		pb = db[10] ? 10'(-db) : 10'(db);
		pc = dc[10] ? 10'(-dc) : 10'(dc);
		if (pa <= pb && pa <= pc) begin
			pick = pa_in;
		end else if (pb <= pc) begin
			pick = pb_in;
		end else begin
			pick = pc_in;
		end
		return pick;
	endfunction

	assign advance = !r_full;
	assign take    = advance && !q_empty;
	assign q_pop   = take;
	assign wr_en   = advance && v_s2;
	assign r_push  = wr_en;
	assign wr_addr = ent_s2.addr[AW-1:0];
	assign slot    = ent_s2.slot[SW-1:0];

	always_comb begin
		a = ent_s2.has_left ? left_q[slot] : 8'd0;
		// a byte written by the previous beat is not yet visible in the store
		b = ent_s2.has_up ? (fwd_s2 ? fwd_d_s2 : rd_s2) : 8'd0;
		c = (ent_s2.has_left && ent_s2.has_up) ? upleft_q[slot] : 8'd0;
		ab_sum = {1'b0, a} + {1'b0, b};
		case (ent_s2.op)
			pngu_pkg::OP_NONE:  recon = ent_s2.x;
			pngu_pkg::OP_SUB:   recon = ent_s2.x + a;
			pngu_pkg::OP_UP:    recon = ent_s2.x + b;
			pngu_pkg::OP_AVG:   recon = ent_s2.x + ab_sum[8:1];
			pngu_pkg::OP_PAETH: recon = ent_s2.x + paeth_pred(a, b, c);
			default:            recon = ent_s2.x;
		endcase
	end

	always_comb begin
		r_item.pixel_byte   = recon;
		r_item.end_of_row   = ent_s2.eor;
		r_item.end_of_image = ent_s2.eoi;
		r_item.bad_filter   = (ent_s2.op == pngu_pkg::OP_PASS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			for (int i = 0; i < MAX_BYTES_PER_PIXEL; i++) begin
				left_q[i]   <= 8'd0;
				upleft_q[i] <= 8'd0;
			end
		end else begin
			if (advance) begin
				v_s2 <= take;
			end
			if (wr_en) begin
				left_q[slot]   <= recon;
				upleft_q[slot] <= b;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			ent_s2   <= q_head;
			fwd_s2   <= v_s2 && (q_head.addr[AW-1:0] == wr_addr);
			fwd_d_s2 <= recon;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= recon;
		end
		if (take) begin
			rd_s2 <= line_mem[q_head.addr[AW-1:0]];
		end
	end

endmodule

// ----- rtl/core/png_scanline_unfilter.sv -----
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// PNG scanline filter reconstruction: filter byte per row, then each byte
// rebuilt from its left, above and above-left neighbours.
//
//   channel   handshake           payload
//   input     push / full         item   (filtered_byte, image_start)
//   result    pop / empty         result (pixel_byte, end_of_row,
//                                         end_of_image, bad_filter)
//   config    cfg_valid/cfg_ready cfg_index, cfg_data
//
// One byte per cycle sustained while the result side keeps up; each byte
// passes the work queue, then the line store read and reconstruction stage.
// Filter bytes are consumed in the front and give no result.
// A write to bytes_per_pixel holds full high while the pixel slot is
// rederived from the column, one bit a cycle.
// full also follows the work queue; the back end stalls only on a full result
// queue. The line store is not cleared at reset.
// ----------------------------------------------------------------------------
module png_scanline_unfilter #(
	parameter int MAX_LINE_BYTES      = 16384,
	parameter int MAX_BYTES_PER_PIXEL = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  pngu_pkg::in_item_t         item,
	output logic                       full,
	input  logic                       pop,
	output pngu_pkg::out_item_t        result,
	output logic                       empty,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [pngu_pkg::CFG_DATA_W-1:0] cfg_data
);

	pngu_pkg::cfg_t      cfg_q;
	logic                cfg_wr;
	logic                bpp_written;

	logic                mid_push;
	logic                mid_full;
	pngu_pkg::work_t     mid_wr;
	logic                mid_pop;
	pngu_pkg::work_t     mid_rd;
	logic                mid_empty;

	logic                out_push;
	logic                out_full;
	pngu_pkg::out_item_t out_wr;

	assign cfg_ready   = 1'b1;
	assign cfg_wr      = cfg_valid && cfg_ready;
	assign bpp_written = cfg_wr && (cfg_index == pngu_pkg::REG_BPP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width_pixels    <= 12'd1;
			cfg_q.image_rows      <= 16'd1;
			cfg_q.bytes_per_pixel <= 4'd4;
		end else if (cfg_wr) begin
			case (cfg_index)
				pngu_pkg::REG_WIDTH: cfg_q.width_pixels    <= cfg_data[11:0];
				pngu_pkg::REG_ROWS:  cfg_q.image_rows      <= cfg_data[15:0];
				pngu_pkg::REG_BPP:   cfg_q.bytes_per_pixel <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	pngu_front #(
		.MAX_LINE_BYTES      (MAX_LINE_BYTES),
		.MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.item        (item),
		.full        (full),
		.cfg         (cfg_q),
		.bpp_written (bpp_written),
		.q_full      (mid_full),
		.q_push      (mid_push),
		.q_entry     (mid_wr)
	);

	pngu_fifo #(
		.entry_t (pngu_pkg::work_t),
		.DEPTH   (2)
	) u_work_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wr     (mid_wr),
		.full   (mid_full),
		.pop    (mid_pop),
		.rd     (mid_rd),
		.empty  (mid_empty)
	);

	pngu_back #(
		.MAX_LINE_BYTES      (MAX_LINE_BYTES),
		.MAX_BYTES_PER_PIXEL (MAX_BYTES_PER_PIXEL)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (mid_empty),
		.q_head  (mid_rd),
		.q_pop   (mid_pop),
		.r_full  (out_full),
		.r_push  (out_push),
		.r_item  (out_wr)
	);

	pngu_fifo #(
		.entry_t (pngu_pkg::out_item_t),
		.DEPTH   (2)
	) u_result_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wr     (out_wr),
		.full   (out_full),
		.pop    (pop),
		.rd     (result),
		.empty  (empty)
	);

	// input must stall while the pixel slot is being rederived
	a_bpp_stall: assert property (@(posedge clk) disable iff (!arst_n)
		bpp_written |=> full)
		else $error("input not stalled after bytes_per_pixel write");

	a_work_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		mid_push |-> !mid_full)
		else $error("work queue written while full");

	a_result_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> !out_full)
		else $error("result queue written while full");

	a_eoi_ends_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_push |-> (!out_wr.end_of_image || out_wr.end_of_row))
		else $error("end of image without end of row");

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for png_scanline_unfilter. Scanline streams go in
// through the push/full side, and results come out through the empty/pop
// side, with random gaps on both sides. A predictor inside the bench rebuilds
// every byte (None, Sub, Up, Average, Paeth and unknown filter types) along
// with the row and image flags. Each result is checked in order, field by
// field. Register settings change between phases, covering zero and
// saturating values, the widest line setting and counters left past their
// bounds.
// ----------------------------------------------------------------------------
module tb;

	localparam int LINE_MAX = 16384;
	localparam int BPP_MAX  = 8;

	localparam logic [7:0] FILT_NONE      = 8'(pngu_pkg::OP_NONE);
	localparam logic [7:0] FILT_SUB       = 8'(pngu_pkg::OP_SUB);
	localparam logic [7:0] FILT_UP        = 8'(pngu_pkg::OP_UP);
	localparam logic [7:0] FILT_AVG       = 8'(pngu_pkg::OP_AVG);
	localparam logic [7:0] FILT_PAETH     = 8'(pngu_pkg::OP_PAETH);
	localparam logic [7:0] FILT_FIRST_BAD = 8'd5;
	localparam logic [7:0] FILT_LAST_BAD  = 8'hFF;

	logic clk;
	logic arst_n;
	logic push;
	pngu_pkg::in_item_t item;
	logic full;
	logic pop;
	pngu_pkg::out_item_t result;
	logic empty;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [pngu_pkg::CFG_DATA_W-1:0] cfg_data;

	// register copy and unfilter state of the predictor
	logic [11:0] width_reg;
	logic [15:0] rows_reg;
	logic [3:0]  bpp_reg;
	logic [7:0]  line_store [LINE_MAX];
	bit          line_written [LINE_MAX];
	logic [7:0]  left_bytes [BPP_MAX];
	logic [7:0]  above_left_bytes [BPP_MAX];
	int unsigned col_now;
	int unsigned row_now;
	logic [7:0]  filter_now;
	bit          awaiting_filter;

	pngu_pkg::out_item_t expected_pixels [$];
	int errors;
	int unsigned sent_items;
	bit steady;

	png_scanline_unfilter #(
		.MAX_LINE_BYTES(LINE_MAX),
		.MAX_BYTES_PER_PIXEL(BPP_MAX)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.item(item),
		.full(full),
		.pop(pop),
		.result(result),
		.empty(empty),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic pngu_pkg::op_t filter_op(logic [7:0] f);
		if (f > FILT_PAETH) return pngu_pkg::OP_PASS;
		return pngu_pkg::op_t'(f[2:0]);
	endfunction

	function automatic int unsigned eff_bpp();
		if (bpp_reg == 0) return 1;
		if (bpp_reg > BPP_MAX) return BPP_MAX;
		return bpp_reg;
	endfunction

	function automatic int unsigned line_len();
		int unsigned len;
		len = ((width_reg == 0) ? 1 : width_reg) * eff_bpp();
		return (len > LINE_MAX) ? LINE_MAX : len;
	endfunction

	// distances at full precision, ties go a, then b
	function automatic logic [7:0] paeth_pick(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		int ia, ib, ic, p, pa, pb, pc;
		ia = int'(a);
		ib = int'(b);
		ic = int'(c);
		p = ia + ib - ic;
		pa = (p > ia) ? p - ia : ia - p;
		pb = (p > ib) ? p - ib : ib - p;
		pc = (p > ic) ? p - ic : ic - p;
		if (pa <= pb && pa <= pc) return a;
		if (pb <= pc) return b;
		return c;
	endfunction

	function automatic logic [7:0] random_data();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic predict_byte(input pngu_pkg::in_item_t it);
		int unsigned bpp, rows, addr, slot;
		logic [7:0] x, a, b, c, r;
		logic [8:0] pair_sum;
		bit has_left, has_up, eor, eoi;
		pngu_pkg::out_item_t pix;
		x = it.filtered_byte;
		if (it.image_start) begin
			col_now = 0;
			row_now = 0;
			awaiting_filter = 1;
		end
		if (awaiting_filter) begin
			filter_now = x;
			col_now = 0;
			awaiting_filter = 0;
			return;
		end
		bpp = eff_bpp();
		rows = (rows_reg == 0) ? 1 : rows_reg;
		addr = col_now % LINE_MAX;
		slot = col_now % bpp;
		has_left = col_now >= bpp;
		has_up = row_now != 0;
		a = has_left ? left_bytes[slot] : 8'h00;
		b = has_up ? line_store[addr] : 8'h00;
		c = (has_left && has_up) ? above_left_bytes[slot] : 8'h00;
		pair_sum = {1'b0, a} + {1'b0, b};
		case (filter_op(filter_now))
			pngu_pkg::OP_SUB:   r = x + a;
			pngu_pkg::OP_UP:    r = x + b;
			pngu_pkg::OP_AVG:   r = x + pair_sum[8:1];
			pngu_pkg::OP_PAETH: r = x + paeth_pick(a, b, c);
			default:            r = x;
		endcase
		left_bytes[slot] = r;
		above_left_bytes[slot] = b;
		line_store[addr] = r;
		line_written[addr] = 1;
		eor = col_now + 1 >= line_len();
		eoi = 0;
		if (eor) begin
			eoi = row_now + 1 >= rows;
			col_now = 0;
			awaiting_filter = 1;
			row_now = eoi ? 0 : ((row_now + 1) & 16'hFFFF);
		end else begin
			col_now = (col_now + 1) & 14'h3FFF;
		end
		pix.pixel_byte = r;
		pix.end_of_row = eor;
		pix.end_of_image = eoi;
		pix.bad_filter = filter_op(filter_now) == pngu_pkg::OP_PASS;
		expected_pixels.push_back(pix);
	endtask

	function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t %s expected %h actual %h", $time, name, want, got);
		end
	endfunction

	always @(posedge clk) begin : check_results
		pngu_pkg::out_item_t want;
		if (arst_n === 1'b1 && pop && !empty) begin
			if (expected_pixels.size() == 0) begin
				errors++;
				$display("%0t result expected none actual %h", $time, result);
			end else begin
				want = expected_pixels.pop_front();
				check_field("pixel_byte", want.pixel_byte, result.pixel_byte);
				check_field("end_of_row", 8'(want.end_of_row), 8'(result.end_of_row));
				check_field("end_of_image", 8'(want.end_of_image),
					8'(result.end_of_image));
				check_field("bad_filter", 8'(want.bad_filter), 8'(result.bad_filter));
			end
		end
	end

	always @(posedge clk)
		pop <= steady || ($urandom_range(99) >= 12);

	task automatic push_byte(input logic [7:0] value, input logic start);
		pngu_pkg::in_item_t it;
		it.filtered_byte = value;
		it.image_start = start;
		// a data byte that would read a line store entry never written restarts the image
		if (!start && !awaiting_filter && row_now != 0 && !line_written[col_now % LINE_MAX])
			it.image_start = 1'b1;
		while (!steady && $urandom_range(99) < 12) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= it;
		@(posedge clk);
		while (full) @(posedge clk);
		predict_byte(it);
		sent_items++;
	endtask

	task automatic send_row(input logic start, input logic [7:0] filt, input int unsigned nbytes);
		push_byte(filt, start);
		repeat (nbytes) push_byte(random_data(), 1'b0);
	endtask

	task automatic directed_row(input logic start, input logic [7:0] filt,
			input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
		push_byte(filt, start);
		push_byte(b0, 1'b0);
		push_byte(b1, 1'b0);
		push_byte(b2, 1'b0);
	endtask

	task automatic wait_idle();
		push <= 1'b0;
		@(posedge clk);
		while (expected_pixels.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_beat(input logic [1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			pngu_pkg::REG_WIDTH: width_reg = data[11:0];
			pngu_pkg::REG_ROWS:  rows_reg = data;
			pngu_pkg::REG_BPP:   bpp_reg = data[3:0];
			default: ;
		endcase
	endtask

	// valid stays high across the three beats
	task automatic set_config(input logic [15:0] w, input logic [15:0] rows, input logic [15:0] bpp);
		wait_idle();
		write_beat(pngu_pkg::REG_WIDTH, w);
		write_beat(pngu_pkg::REG_ROWS, rows);
		write_beat(pngu_pkg::REG_BPP, bpp);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_filter_rules();
		set_config(3, 3, 1);
		directed_row(1'b1, FILT_NONE, 8'h00, 8'hFF, 8'h80);
		directed_row(1'b0, FILT_SUB, 8'hFF, 8'h01, 8'h7F);
		directed_row(1'b0, FILT_AVG, 8'hFF, 8'hFF, 8'h00);
		directed_row(1'b1, FILT_FIRST_BAD, 8'h12, 8'h34, 8'hFF);
		directed_row(1'b0, FILT_PAETH, 8'h00, 8'hFF, 8'h01);
		directed_row(1'b0, FILT_UP, 8'h05, 8'hFB, 8'h00);
	endtask

	task automatic test_register_extremes();
		// zero registers count as one, next image starts without image_start
		set_config(0, 0, 0);
		send_row(1'b1, FILT_SUB, 1);
		send_row(1'b0, FILT_AVG, 1);
		send_row(1'b0, FILT_LAST_BAD, 1);
		// junk above the register width, bytes per pixel saturates
		set_config(16'hF002, 2, 16'hFFF9);
		send_row(1'b1, FILT_PAETH, 16);
		send_row(1'b0, FILT_PAETH, 16);
		set_config(1, 16'hFFFF, 15);
		send_row(1'b1, FILT_UP, 8);
		send_row(1'b0, FILT_SUB, 8);
		send_row(1'b0, FILT_AVG, 8);
	endtask

	task automatic test_midimage_change();
		set_config(6, 5, 2);
		send_row(1'b1, FILT_PAETH, 12);
		send_row(1'b0, FILT_SUB, 12);
		send_row(1'b0, FILT_AVG, 5);
		// column now past the shorter line, next byte ends the row
		set_config(1, 5, 3);
		push_byte(random_data(), 1'b0);
		send_row(1'b0, FILT_PAETH, 2);
		// row now past the last row, the row end also ends the image
		set_config(1, 2, 3);
		push_byte(random_data(), 1'b0);
	endtask

	task automatic test_long_line();
		// widest setting, row cut short and the next image restarts
		set_config(12'hFFF, 1, 8);
		send_row(1'b1, FILT_SUB, 40);
	endtask

	task automatic test_random_stream();
		int unsigned base, rows_eff, nbytes;
		logic [15:0] w, r, b;
		logic [7:0] filt;
		bit must_start;
		base = sent_items;
		must_start = 1;
		while (sent_items < base + 450) begin
			w = 16'($urandom_range(8));
			r = 16'($urandom_range(4));
			b = ($urandom_range(9) == 0) ? 16'($urandom_range(15)) : 16'($urandom_range(8, 1));
			set_config(w, r, b);
			rows_eff = (rows_reg == 0) ? 1 : rows_reg;
			repeat ($urandom_range(3, 1)) begin
				for (int row = 0; row < rows_eff; row++) begin
					steady = (sent_items >= base + 170) && (sent_items < base + 320);
					filt = ($urandom_range(99) < 85) ? 8'($urandom_range(FILT_PAETH)) :
						8'($urandom_range(FILT_LAST_BAD, FILT_FIRST_BAD));
					nbytes = line_len();
					// broken row, cut short and followed by a fresh image
					if ($urandom_range(99) < 4) nbytes = $urandom_range(nbytes - 1);
					send_row((row == 0) && (must_start || $urandom_range(4) != 0), filt, nbytes);
					must_start = nbytes < line_len();
					if (must_start) break;
				end
			end
		end
		steady = 0;
	endtask

	initial begin
		push = 1'b0;
		item = '0;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = pngu_pkg::REG_WIDTH;
		cfg_data = '0;
		arst_n = 1'b0;
		steady = 0;
		errors = 0;
		sent_items = 0;
		width_reg = 1;
		rows_reg = 1;
		bpp_reg = 4;
		for (int i = 0; i < BPP_MAX; i++) begin
			left_bytes[i] = 8'h00;
			above_left_bytes[i] = 8'h00;
		end
		col_now = 0;
		row_now = 0;
		filter_now = 8'h00;
		awaiting_filter = 1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		test_filter_rules();
		test_register_extremes();
		test_midimage_change();
		test_long_line();
		test_random_stream();
		wait_idle();
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#8000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
